// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/ffra_pkg.sv =====
// package with sizes, codes and state type of the range allocator
`default_nettype none
package ffra_pkg;
    localparam int MAX_RANGES = 64;
    localparam int MAX_ALIGN_LOG2 = 12;
    localparam int IDX_W = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int ENTRY_W = 64;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RANGES);
    localparam logic [31:0] POOL_RESET = 32'd65536;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APP_PAD,
        S_APP_TAIL,
        S_APP_USED,
        S_UFREE_APP,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

// ===== design/ffra_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module ffra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== design/ffra_ctrl.sv =====
// sequencer: scan, compaction and appends over the two range memories
`default_nettype none
module ffra_ctrl import ffra_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               in_go,
    input  wire logic               in_action,
    input  wire logic [31:0]        in_size,
    input  wire logic [3:0]         in_lg,
    input  wire logic [31:0]        in_where,
    output logic                    busy,
    output logic                    res_valid,
    output logic [31:0]             res_offset,
    output logic [1:0]              res_status,
    output logic                    f_we,
    output logic [IDX_W-1:0]        f_addr,
    output logic [ENTRY_W-1:0]      f_wdata,
    input  wire logic [ENTRY_W-1:0] f_rdata,
    output logic                    u_we,
    output logic [IDX_W-1:0]        u_addr,
    output logic [ENTRY_W-1:0]      u_wdata,
    input  wire logic [ENTRY_W-1:0] u_rdata
);
    state_t state_reg, state_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next, ucnt_reg, ucnt_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic act_reg, act_next;
    logic [32:0] need_reg, need_next;
    logic [31:0] mask_reg, mask_next;
    logic [31:0] where_reg, where_next;
    logic [31:0] st_reg, st_next, len_reg, len_next, pad_reg, pad_next;
    logic [ENTRY_W-1:0] hold_reg, hold_next;
    logic [1:0] status_reg, status_next;
    logic [31:0] off_reg, off_next;
    // high on a free: the used list is scanned and shifts; low: the free list
    logic use_u;

    logic [3:0] lg_c;
    logic [31:0] mask_c;
    logic [31:0] s_c, l_c, p_c;
    logic [33:0] fit_sum;
    logic [33:0] rem_c;
    logic [ENTRY_W-1:0] rd;

    assign lg_c = (in_lg > 4'(MAX_ALIGN_LOG2)) ? 4'(MAX_ALIGN_LOG2) : in_lg;
    assign mask_c = (32'd1 << lg_c) - 32'd1;
    assign rd = use_u ? u_rdata : f_rdata;
    assign s_c = f_rdata[31:0];
    assign l_c = f_rdata[63:32];
    assign p_c = (32'd0 - s_c) & mask_reg;
    assign fit_sum = {2'b0, p_c} + {1'b0, need_reg};
    assign rem_c = {2'b0, len_reg} - {2'b0, pad_reg} - {1'b0, need_reg};
    assign use_u = act_reg == ACT_FREE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            fcnt_reg <= CNT_W'(1);
            ucnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fcnt_reg <= fcnt_next;
            ucnt_reg <= ucnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        act_reg <= act_next;
        need_reg <= need_next;
        mask_reg <= mask_next;
        where_reg <= where_next;
        st_reg <= st_next;
        len_reg <= len_next;
        pad_reg <= pad_next;
        hold_reg <= hold_next;
        status_reg <= status_next;
        off_reg <= off_next;
    end

    always_comb
    begin
        state_next = state_reg;
        fcnt_next = fcnt_reg;
        ucnt_next = ucnt_reg;
        i_next = i_reg;
        act_next = act_reg;
        need_next = need_reg;
        mask_next = mask_reg;
        where_next = where_reg;
        st_next = st_reg;
        len_next = len_reg;
        pad_next = pad_reg;
        hold_next = hold_reg;
        status_next = status_reg;
        off_next = off_reg;
        f_we = 1'b0;
        f_addr = i_reg[IDX_W-1:0];
        f_wdata = hold_reg;
        u_we = 1'b0;
        u_addr = i_reg[IDX_W-1:0];
        u_wdata = hold_reg;
        busy = state_reg != S_IDLE;
        res_valid = 1'b0;
        res_offset = off_reg;
        res_status = status_reg;
        case (state_reg)
            S_INIT:
            begin
                // first cycle after reset: whole default pool as entry 0, or the cfg_wdata pool if cfg_we
                f_addr = '0;
                if (cfg_we)
                begin
                    f_we = cfg_wdata != 32'd0;
                    f_wdata = {cfg_wdata, 32'd0};
                    fcnt_next = (cfg_wdata != 32'd0) ? CNT_W'(1) : '0;
                    ucnt_next = '0;
                end
                else
                begin
                    f_we = 1'b1;
                    f_wdata = {POOL_RESET, 32'd0};
                end
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    // whole pool as one free range, or an empty free list for size zero
                    f_we = cfg_wdata != 32'd0;
                    f_addr = '0;
                    f_wdata = {cfg_wdata, 32'd0};
                    fcnt_next = (cfg_wdata != 32'd0) ? CNT_W'(1) : '0;
                    ucnt_next = '0;
                end
                else if (in_go)
                begin
                    act_next = in_action;
                    mask_next = mask_c;
                    need_next = ({1'b0, in_size} + {1'b0, mask_c}) & ~{1'b0, mask_c};
                    where_next = in_where;
                    i_next = '0;
                    off_next = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (i_reg >= (use_u ? ucnt_reg : fcnt_reg))
                begin
                    status_next = use_u ? ST_NOTFOUND : ST_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (use_u)
                begin
                    if (u_rdata[31:0] == where_reg)
                    begin
                        hold_next = u_rdata;
                        if (fcnt_reg >= MAX_CNT)
                        begin
                            status_next = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            i_next = i_reg + CNT_W'(1);
                            state_next = S_SHIFT_RD;
                        end
                    end
                    else
                    begin
                        i_next = i_reg + CNT_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else if ({2'b0, l_c} >= fit_sum)
                begin
                    st_next = s_c;
                    len_next = l_c;
                    pad_next = p_c;
                    i_next = i_reg + CNT_W'(1);
                    state_next = S_SHIFT_RD;
                    if ((fcnt_reg - CNT_W'(1) + CNT_W'(p_c != 0)
                            + CNT_W'(l_c - p_c != need_reg[31:0])) > MAX_CNT
                        || ucnt_reg >= MAX_CNT)
                    begin
                        status_next = ST_FULL;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                // i_reg points at the entry after the hole
                if (i_reg >= (use_u ? ucnt_reg : fcnt_reg))
                begin
                    if (use_u)
                    begin
                        ucnt_next = ucnt_reg - CNT_W'(1);
                        state_next = S_UFREE_APP;
                    end
                    else
                    begin
                        fcnt_next = fcnt_reg - CNT_W'(1);
                        state_next = S_APP_PAD;
                    end
                end
                else
                begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                f_addr = i_reg[IDX_W-1:0] - IDX_W'(1);
                u_addr = f_addr;
                f_wdata = rd;
                u_wdata = rd;
                f_we = !use_u;
                u_we = use_u;
                i_next = i_reg + CNT_W'(1);
                state_next = S_SHIFT_RD;
            end
            S_UFREE_APP:
            begin
                f_we = 1'b1;
                f_addr = fcnt_reg[IDX_W-1:0];
                f_wdata = hold_reg;
                fcnt_next = fcnt_reg + CNT_W'(1);
                status_next = ST_OK;
                state_next = S_DONE;
            end
            S_APP_PAD:
            begin
                if (pad_reg != 32'd0)
                begin
                    f_we = 1'b1;
                    f_addr = fcnt_reg[IDX_W-1:0];
                    f_wdata = {pad_reg, st_reg};
                    fcnt_next = fcnt_reg + CNT_W'(1);
                end
                state_next = S_APP_TAIL;
            end
            S_APP_TAIL:
            begin
                if (rem_c != 34'd0)
                begin
                    f_we = 1'b1;
                    f_addr = fcnt_reg[IDX_W-1:0];
                    f_wdata = {rem_c[31:0], st_reg + pad_reg + need_reg[31:0]};
                    fcnt_next = fcnt_reg + CNT_W'(1);
                end
                state_next = S_APP_USED;
            end
            S_APP_USED:
            begin
                u_we = 1'b1;
                u_addr = ucnt_reg[IDX_W-1:0];
                u_wdata = {need_reg[31:0], st_reg + pad_reg};
                ucnt_next = ucnt_reg + CNT_W'(1);
                off_next = st_reg + pad_reg;
                status_next = ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                res_offset = (status_reg == ST_OK) ? off_reg : 32'd0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== design/first_fit_range_allocator_unit.sv =====
// top level of the first-fit range allocator
// usage:
//   s_axis carries one request a transfer; s_axis_tuser is the action
//   (0 allocate, 1 free). m_axis returns one result per request.
//   cfg_we with cfg_wdata sets pool_size and resets both range lists;
//   write it only while no request is in flight.
// sequencing:
//   one request at a time; s_axis_tready is high when the sequencer is idle,
//   no result is pending and cfg_we is low. a request scans its list, each
//   entry read from memory then compared, then compacts the list after the
//   erased entry, reading then writing each moved entry, then appends up to
//   three entries; a miss or a full list ends the request after the scan.
// reset:
//   pool_size returns to 65536, the used list is empty; the first cycle
//   after reset writes the whole pool as free entry 0; counts bound reads.
// stall:
//   the result sits in an output register; a stalled receiver holds it and
//   the next request is not taken until that register is free.
`default_nettype none
module first_fit_range_allocator_unit import ffra_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // req_size, align_log2, free_offset, zero pad
    input  wire logic        s_axis_tuser,   // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // offset, status, zero pad
);
    logic busy, res_valid, f_we, u_we;
    logic [31:0] res_offset;
    logic [1:0] res_status;
    logic [IDX_W-1:0] f_addr, u_addr;
    logic [ENTRY_W-1:0] f_wdata, f_rdata, u_wdata, u_rdata;
    logic out_valid_reg;
    logic [33:0] out_data_reg;
    logic go;

    assign s_axis_tready = !busy && !out_valid_reg && !cfg_we;
    assign go = s_axis_tvalid && s_axis_tready;

    ffra_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_go(go), .in_action(s_axis_tuser), .in_size(s_axis_tdata[31:0]),
        .in_lg(s_axis_tdata[35:32]), .in_where(s_axis_tdata[67:36]),
        .busy(busy), .res_valid(res_valid), .res_offset(res_offset),
        .res_status(res_status),
        .f_we(f_we), .f_addr(f_addr), .f_wdata(f_wdata), .f_rdata(f_rdata),
        .u_we(u_we), .u_addr(u_addr), .u_wdata(u_wdata), .u_rdata(u_rdata)
    );

    ffra_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_free_ram (
        .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
    );

    ffra_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_used_ram (
        .clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wdata), .rdata(u_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= {res_status, res_offset};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {6'd0, out_data_reg};
endmodule
`default_nettype wire

// ===== design/ffra_checker.sv =====
// port-level checks for the range allocator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module ffra_checker import ffra_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    `CHK_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `CHK_IMPL(a_fail_zero, clk, rst_n, m_axis_tvalid && m_axis_tdata[33:32] != ST_OK, m_axis_tdata[31:0] == 32'd0, "failed result with nonzero offset")
    `CHK_IMPL(a_no_take, clk, rst_n, m_axis_tvalid, !s_axis_tready, "request taken while result pending")
    `CHK_NEXT(a_one_res, clk, rst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid, "result without work")
endmodule

bind first_fit_range_allocator_unit ffra_checker u_ffra_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
